FILE: design/status_led_pattern_generator_macros.svh
// Assertion macros shared by the status LED pattern generator modules.
`ifndef STATUS_LED_PATTERN_GENERATOR_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SLPG_ASSERT_IMP(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("slpg check failed");

// Next-cycle implication, checked out of reset.
`define SLPG_ASSERT_NXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("slpg check failed");

`endif

FILE: design/slpg_pkg.sv
// Shared types and constants for the status LED pattern generator.
package slpg_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MODE   = 2'd1;
    localparam logic [1:0] CMD_NOTIFY = 2'd2;

    // display modes
    localparam logic [2:0] MODE_OFF       = 3'd0;
    localparam logic [2:0] MODE_SEARCHING = 3'd1;
    localparam logic [2:0] MODE_CONNECTED = 3'd2;
    localparam logic [2:0] MODE_CLICKING  = 3'd3;
    localparam logic [2:0] MODE_ERROR     = 3'd4;

    localparam logic [7:0] NOTIFY_IDLE = 8'hFF;
    localparam logic [7:0] PHASE_LAST  = 8'd199;
    localparam logic [3:0] SUB10_LAST  = 4'd9;
    localparam logic [5:0] SUB50_LAST  = 6'd49;

    localparam int ITEM_BYTES   = 2;
    localparam int RESULT_BYTES = 1;

    // cmd in the low bits
    typedef struct packed {
        logic [5:0] blink_count;
        logic [2:0] mode_value;
        logic [1:0] cmd;
    } item_t;

    // blue_pin in the low bit
    typedef struct packed {
        logic [2:0] current_mode;
        logic       notify_active;
        logic       green_pin;
        logic       blue_pin;
    } result_t;

endpackage

FILE: design/slpg_core.sv
// LED pattern state registers and the per-command update logic.
module slpg_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  slpg_pkg::item_t  item,
    input  logic             lit_level,
    output slpg_pkg::result_t result
);
    import slpg_pkg::*;
    `include "status_led_pattern_generator_macros.svh"

    logic [7:0] phase_reg, phase_next;
    logic [3:0] sub10_reg, sub10_next;
    logic [5:0] sub50_reg, sub50_next;
    logic [2:0] mode_reg, mode_next;
    logic [2:0] saved_reg, saved_next;
    logic [7:0] notify_reg, notify_next;
    logic       btog_reg, btog_next;
    logic       gtog_reg, gtog_next;
    logic       blit_reg, blit_next;
    logic       glit_reg, glit_next;

    logic       notify_on;
    logic       hit8, hit10, hit50;
    logic       lit;
    logic [7:0] notify_dec;

    assign notify_on  = (notify_reg != 8'd0) && !notify_reg[7];
    assign notify_dec = notify_reg - 8'd1;
    assign lit        = ~notify_reg[0];

    always_comb
    begin
        phase_next  = phase_reg;
        sub10_next  = sub10_reg;
        sub50_next  = sub50_reg;
        mode_next   = mode_reg;
        saved_next  = saved_reg;
        notify_next = notify_reg;
        btog_next   = btog_reg;
        gtog_next   = gtog_reg;
        blit_next   = blit_reg;
        glit_next   = glit_reg;

        // residues of the phase after the advance
        phase_next = (phase_reg == PHASE_LAST) ? 8'd0 : phase_reg + 8'd1;
        sub10_next = (sub10_reg == SUB10_LAST) ? 4'd0 : sub10_reg + 4'd1;
        sub50_next = (sub50_reg == SUB50_LAST) ? 6'd0 : sub50_reg + 6'd1;
        hit8  = (phase_next[2:0] == 3'd0);
        hit10 = (sub10_reg == SUB10_LAST);
        hit50 = (sub50_reg == SUB50_LAST);

        if (!(step && item.cmd == CMD_TICK))
        begin
            phase_next = phase_reg;
            sub10_next = sub10_reg;
            sub50_next = sub50_reg;
        end

        if (step)
        begin
            unique case (item.cmd)
                CMD_TICK:
                begin
                    if (notify_on)
                    begin
                        blit_next = lit;
                        glit_next = lit;
                        if (hit8)
                        begin
                            if (notify_dec == 8'd0)
                            begin
                                mode_next   = saved_reg;
                                notify_next = NOTIFY_IDLE;
                            end
                            else
                            begin
                                notify_next = notify_dec;
                            end
                        end
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_OFF:
                            begin
                                blit_next = 1'b0;
                                glit_next = 1'b0;
                            end
                            MODE_SEARCHING:
                            begin
                                if (hit50)
                                begin
                                    btog_next = ~btog_reg;
                                    blit_next = ~btog_reg;
                                end
                                glit_next = 1'b0;
                            end
                            MODE_CONNECTED:
                            begin
                                blit_next = 1'b1;
                                glit_next = 1'b0;
                            end
                            MODE_CLICKING:
                            begin
                                blit_next = 1'b1;
                                if (hit10)
                                begin
                                    gtog_next = ~gtog_reg;
                                    glit_next = ~gtog_reg;
                                end
                            end
                            MODE_ERROR:
                            begin
                                if (hit10)
                                begin
                                    gtog_next = ~gtog_reg;
                                    blit_next = ~gtog_reg;
                                    glit_next = ~gtog_reg;
                                end
                            end
                            default:
                            begin
                                // undefined modes leave the LEDs alone
                            end
                        endcase
                    end
                end
                CMD_MODE:
                begin
                    mode_next = item.mode_value;
                    btog_next = 1'b0;
                    gtog_next = 1'b0;
                end
                CMD_NOTIFY:
                begin
                    saved_next  = mode_reg;
                    notify_next = {1'b0, item.blink_count, 1'b0};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.blue_pin      = blit_next ^ ~lit_level;
        result.green_pin     = glit_next ^ ~lit_level;
        result.notify_active = (notify_next != 8'd0) && !notify_next[7];
        result.current_mode  = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 8'd0;
            sub10_reg  <= 4'd0;
            sub50_reg  <= 6'd0;
            mode_reg   <= MODE_OFF;
            saved_reg  <= MODE_OFF;
            notify_reg <= NOTIFY_IDLE;
            btog_reg   <= 1'b0;
            gtog_reg   <= 1'b0;
            blit_reg   <= 1'b0;
            glit_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sub10_reg  <= sub10_next;
            sub50_reg  <= sub50_next;
            mode_reg   <= mode_next;
            saved_reg  <= saved_next;
            notify_reg <= notify_next;
            btog_reg   <= btog_next;
            gtog_reg   <= gtog_next;
            blit_reg   <= blit_next;
            glit_reg   <= glit_next;
        end
    end

    // the only count with the top bit set is the idle mark
    `SLPG_ASSERT_IMP(a_notify_range, notify_reg[7], notify_reg == NOTIFY_IDLE)
    // the side counters stay in step with the phase
    `SLPG_ASSERT_IMP(a_phase_sync, phase_reg == 8'd0, (sub10_reg == 4'd0) && (sub50_reg == 6'd0))
    // no phase movement without a tick
    `SLPG_ASSERT_NXT(a_phase_hold, !(step && item.cmd == CMD_TICK), $stable(phase_reg))

endmodule

FILE: design/status_led_pattern_generator.sv
// Status LED pattern generator: input stage, output register and polarity register.
// A beat accepted on s_axis passes through the input register, then the result register
// holding the updated state's outputs, before it appears on m_axis. Throughput: one beat
// per cycle while m_axis_tready holds; each stage advances whenever the next one frees.
// Reset (rst_n, asynchronous, active low): both stages empty, LEDs unlit, mode off,
// no notify pending, phase zero, lit level set to 1 (pins high when lit).
module status_led_pattern_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [8*slpg_pkg::ITEM_BYTES-1:0]    s_axis_tdata,  // cmd, mode_value, blink_count
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [8*slpg_pkg::RESULT_BYTES-1:0]  m_axis_tdata,  // blue_pin, green_pin,
                                                                // notify_active, current_mode
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata      // lit level: 1 = pin high when lit
);
    import slpg_pkg::*;
    `include "status_led_pattern_generator_macros.svh"

    localparam int ItemW   = $bits(item_t);
    localparam int ResultW = $bits(result_t);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    lit_level_reg;
    logic    advance;
    result_t result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8*RESULT_BYTES-ResultW){1'b0}}, out_data_reg};

    slpg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_valid_reg && advance),
        .item        (in_item_reg),
        .lit_level   (lit_level_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lit_level_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                lit_level_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= item_t'(s_axis_tdata[ItemW-1:0]);
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= result;
        end
    end

    // a held input beat always reaches the result register once it frees
    `SLPG_ASSERT_NXT(a_move, in_valid_reg && advance, out_valid_reg)
    // input side only stalls when both stages are full and the sink waits
    `SLPG_ASSERT_IMP(a_stall, !s_axis_tready, in_valid_reg && out_valid_reg && !m_axis_tready)
    // a waiting result is not overwritten
    `SLPG_ASSERT_NXT(a_hold, out_valid_reg && !m_axis_tready, $stable(out_data_reg))

endmodule
